[hdl/lfcf_pkg.sv]
// shared constants, codes and types of the lowpass feedback comb filter
// used by lfcf_ctrl, lfcf_dp and lowpass_feedback_comb_filter; no dependencies
package lfcf_pkg;

  localparam int DEPTH       = 8192;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int WHOLE_W     = 13;
  localparam int GAIN_W      = 16;
  localparam int LP_W        = SAMPLE_BITS + 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  // 0.999 in Q0.16
  localparam logic [GAIN_W-1:0] GAIN_LIMIT = GAIN_W'(65470);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRACTION = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_GAIN   = CFG_IDX_W'(3);

  // input operation codes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_MUL,
    S_DLY,
    S_LP,
    S_FB,
    S_WR
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic rd;
    logic mul;
    logic dly;
    logic lp;
    logic fb;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

  typedef struct packed {
    logic [WHOLE_W-1:0]   delay_whole;
    logic [FRAC_BITS-1:0] delay_fraction;
    logic [GAIN_W-1:0]    feedback_gain;
    logic [GAIN_W-1:0]    lowpass_gain;
  } cfg_t;

endpackage

[hdl/lowpass_feedback_comb_filter.sv]
// Lowpass feedback comb filter, top level.
// Channels: in_valid/in_stall carry in_op and in_sample_in (Q1.15); in_op
// clear zeroes the delay memory, pointer and lowpass state and gives no word.
// out_valid/out_stall carry out_sample_out, the delayed sample interpolated
// between the taps delay_whole and delay_whole+1 behind the write pointer.
// cfg_valid/cfg_ready write delay_whole, delay_fraction, feedback_gain and
// lowpass_gain by cfg_index 0..3; other indexes are ignored. cfg_ready is
// always high; write only while no word is in flight.
// Sequence: after acceptance of a process word the sequencer steps through
// read, interpolation multiply, add, lowpass update, feedback multiply and
// write, then returns to idle to accept the next word; a new word is not
// taken until the previous one has reached its write.
// Reset and each clear word start a clearing pass over the delay memory (one
// entry per cycle) during which in_stall is high.
// A stalled result waits in the output register; the next word is still
// accepted and computed, and holds before its memory write until that
// result has been taken.
// Depends on lfcf_pkg, lfcf_ctrl and lfcf_dp.
module lowpass_feedback_comb_filter (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_op,
  input  logic signed [lfcf_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [lfcf_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [lfcf_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lfcf_pkg::CFG_DATA_W-1:0]          cfg_data
);

  lfcf_pkg::cfg_t    cfg_r, cfg_nxt;
  lfcf_pkg::cmd_t    cmd;
  lfcf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfcf_pkg::REG_DELAY_WHOLE:
          cfg_nxt.delay_whole = cfg_data[lfcf_pkg::WHOLE_W-1:0];
        lfcf_pkg::REG_DELAY_FRACTION:
          cfg_nxt.delay_fraction = cfg_data[lfcf_pkg::FRAC_BITS-1:0];
        lfcf_pkg::REG_FEEDBACK_GAIN:
          cfg_nxt.feedback_gain = cfg_data[lfcf_pkg::GAIN_W-1:0];
        lfcf_pkg::REG_LOWPASS_GAIN:
          cfg_nxt.lowpass_gain = cfg_data[lfcf_pkg::GAIN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_whole    <= lfcf_pkg::WHOLE_W'(1323);
      cfg_r.delay_fraction <= '0;
      cfg_r.feedback_gain  <= lfcf_pkg::GAIN_W'(6554);
      cfg_r.lowpass_gain   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lfcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lfcf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg_r),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out)
  );

endmodule

[hdl/lfcf_ctrl.sv]
// sequencer of the lowpass feedback comb filter: input and result handshakes,
// clearing pass and the per-word step order; uses lfcf_pkg
module lfcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lfcf_pkg::status_t  status,
  output lfcf_pkg::cmd_t     cmd
);

  lfcf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall  = (state_r != lfcf_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfcf_pkg::S_CLR: begin
        if (status.clr_last) state_nxt = lfcf_pkg::S_IDLE;
      end
      lfcf_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == lfcf_pkg::OP_CLEAR) ? lfcf_pkg::S_CLR : lfcf_pkg::S_RD;
        end
      end
      lfcf_pkg::S_RD:  state_nxt = lfcf_pkg::S_MUL;
      lfcf_pkg::S_MUL: state_nxt = lfcf_pkg::S_DLY;
      lfcf_pkg::S_DLY: state_nxt = lfcf_pkg::S_LP;
      lfcf_pkg::S_LP:  state_nxt = lfcf_pkg::S_FB;
      lfcf_pkg::S_FB:  state_nxt = lfcf_pkg::S_WR;
      lfcf_pkg::S_WR: begin
        if (out_free) state_nxt = lfcf_pkg::S_IDLE;
      end
      default: state_nxt = lfcf_pkg::S_CLR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      lfcf_pkg::S_CLR:  cmd.clr_step = 1'b1;
      lfcf_pkg::S_IDLE: begin
        cmd.load      = accept && (in_op == lfcf_pkg::OP_PROCESS);
        cmd.clr_start = accept && (in_op == lfcf_pkg::OP_CLEAR);
      end
      lfcf_pkg::S_RD:  cmd.rd  = 1'b1;
      lfcf_pkg::S_MUL: cmd.mul = 1'b1;
      lfcf_pkg::S_DLY: cmd.dly = 1'b1;
      lfcf_pkg::S_LP:  cmd.lp  = 1'b1;
      lfcf_pkg::S_FB:  cmd.fb  = 1'b1;
      lfcf_pkg::S_WR:  cmd.wr  = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.wr) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // reset starts with a clearing pass over the delay memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfcf_pkg::S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a finished word never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (!out_valid_r || !out_stall))
    else $error("lfcf_ctrl: result overwritten while stalled");

  // only one writer of the delay memory at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr, cmd.clr_step}))
    else $error("lfcf_ctrl: clear and sample write collide");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == lfcf_pkg::OP_PROCESS) |=> state_r == lfcf_pkg::S_RD)
    else $error("lfcf_ctrl: process word did not start a read");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == lfcf_pkg::OP_CLEAR) |=> (state_r == lfcf_pkg::S_CLR && !out_valid_nxt)
      || (state_r == lfcf_pkg::S_CLR && out_valid_r))
    else $error("lfcf_ctrl: clear word did not start a clearing pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfcf_pkg::S_CLR && status.clr_last) |=> state_r == lfcf_pkg::S_IDLE)
    else $error("lfcf_ctrl: clearing pass did not end");
`endif

endmodule

[hdl/lfcf_dp.sv]
// datapath of the lowpass feedback comb filter: delay memory, pointers,
// interpolation, lowpass state and feedback write; uses lfcf_pkg
module lfcf_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lfcf_pkg::cmd_t                           cmd,
  output lfcf_pkg::status_t                        status,
  input  lfcf_pkg::cfg_t                           cfg,
  input  logic signed [lfcf_pkg::SAMPLE_BITS-1:0]  sample_in,
  output logic signed [lfcf_pkg::SAMPLE_BITS-1:0]  sample_out
);

  localparam int AW     = lfcf_pkg::ADDR_W;
  localparam int SB     = lfcf_pkg::SAMPLE_BITS;
  localparam int FB     = lfcf_pkg::FRAC_BITS;
  localparam int GW     = lfcf_pkg::GAIN_W;
  localparam int LW     = lfcf_pkg::LP_W;
  localparam int DIFF_W = SB + 1;
  localparam int PI_W   = DIFF_W + FB + 1;
  localparam int PROD_W = GW + 1 + LW;
  localparam int WX     = (lfcf_pkg::WHOLE_W > AW ? lfcf_pkg::WHOLE_W : AW) + 1;

  localparam logic [AW-1:0]   LAST    = AW'(lfcf_pkg::DEPTH - 1);
  localparam logic [AW:0]     DEPTH_X = (AW + 1)'(lfcf_pkg::DEPTH);
  localparam logic [WX-1:0]   WMAX    = WX'(lfcf_pkg::DEPTH - 1);
  localparam logic [WX-1:0]   WONE    = WX'(1);
  localparam logic signed [PI_W-1:0]   PI_HALF = PI_W'(1) << (FB - 1);
  localparam logic signed [PROD_W-1:0] G_HALF  = PROD_W'(1) << (GW - 1);
  localparam logic signed [PROD_W-1:0] LP_MAX  =
    {{(PROD_W - LW + 1){1'b0}}, {(LW - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] LP_MIN  = ~LP_MAX;
  localparam logic signed [PROD_W-1:0] SMP_MAX =
    {{(PROD_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SMP_MIN = ~SMP_MAX;

  logic signed [SB-1:0] mem [lfcf_pkg::DEPTH];

  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic signed [LW-1:0]   lp_state_r, lp_state_nxt;
  logic [AW-1:0]          rd1_r, rd2_r;
  logic signed [SB-1:0]   s1_r, s2_r;
  logic signed [SB-1:0]   x_r;
  logic [FB-1:0]          frac_r;
  logic [GW-1:0]          g1e_r, g2e_r;
  logic signed [PI_W-1:0] pi_r;
  logic signed [PROD_W-1:0] pl_r, pf_r;
  logic signed [SB-1:0]   dly_r;
  logic signed [SB-1:0]   out_r;

  logic [WX-1:0]          whole_x;
  logic [AW-1:0]          whole_a;
  logic [AW-1:0]          rd1, rd2;
  logic [AW:0]            wrap_sum;
  logic [GW-1:0]          g2e, g1_room, g1e;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PI_W-1:0] pi_rnd, dly_sum;
  logic signed [PROD_W-1:0] pl_rnd, lp_sum, pf_rnd, wr_sum;
  logic signed [LW-1:0]   lp_sat;
  logic signed [SB-1:0]   wr_sat;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic signed [SB-1:0]   mem_wd;

  // read addresses: whole delay clamped to 1 .. DEPTH-1, ring wrap
  always_comb begin
    whole_x = WX'(cfg.delay_whole);
    if (whole_x == '0) begin
      whole_x = WONE;
    end else if (whole_x > WMAX) begin
      whole_x = WMAX;
    end
    whole_a  = whole_x[AW-1:0];
    wrap_sum = {1'b0, wp_r} + DEPTH_X - {1'b0, whole_a};
    rd1      = (wp_r >= whole_a) ? (wp_r - whole_a) : wrap_sum[AW-1:0];
    rd2      = (rd1 == '0) ? LAST : (rd1 - AW'(1));
  end

  // gain limit keeps g1 + g2 at or below 0.999
  always_comb begin
    g2e     = (cfg.lowpass_gain > lfcf_pkg::GAIN_LIMIT) ? lfcf_pkg::GAIN_LIMIT
                                                         : cfg.lowpass_gain;
    g1_room = lfcf_pkg::GAIN_LIMIT - g2e;
    g1e     = (cfg.feedback_gain > g1_room) ? g1_room : cfg.feedback_gain;
  end

  always_comb begin
    diff    = DIFF_W'(s2_r) - DIFF_W'(s1_r);
    pi_rnd  = (pi_r + PI_HALF) >>> FB;
    dly_sum = PI_W'(s1_r) + pi_rnd;
    pl_rnd  = (pl_r + G_HALF) >>> GW;
    lp_sum  = PROD_W'(dly_r) + pl_rnd;
    if (lp_sum > LP_MAX) begin
      lp_sat = LP_MAX[LW-1:0];
    end else if (lp_sum < LP_MIN) begin
      lp_sat = LP_MIN[LW-1:0];
    end else begin
      lp_sat = lp_sum[LW-1:0];
    end
    pf_rnd = (pf_r + G_HALF) >>> GW;
    wr_sum = PROD_W'(x_r) + pf_rnd;
    if (wr_sum > SMP_MAX) begin
      wr_sat = SMP_MAX[SB-1:0];
    end else if (wr_sum < SMP_MIN) begin
      wr_sat = SMP_MIN[SB-1:0];
    end else begin
      wr_sat = wr_sum[SB-1:0];
    end
  end

  always_comb begin
    wp_nxt       = wp_r;
    clr_cnt_nxt  = clr_cnt_r;
    lp_state_nxt = lp_state_r;
    if (cmd.clr_start) begin
      wp_nxt       = '0;
      clr_cnt_nxt  = '0;
      lp_state_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = (clr_cnt_r == LAST) ? '0 : (clr_cnt_r + AW'(1));
    end else if (cmd.lp) begin
      lp_state_nxt = lp_sat;
    end else if (cmd.wr) begin
      wp_nxt = (wp_r == LAST) ? '0 : (wp_r + AW'(1));
    end
  end

  always_comb begin
    mem_we = cmd.clr_step || cmd.wr;
    mem_wa = cmd.clr_step ? clr_cnt_r : wp_r;
    mem_wd = cmd.clr_step ? '0 : wr_sat;
  end

  assign status.clr_last = (clr_cnt_r == LAST);
  assign sample_out      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      clr_cnt_r  <= '0;
      lp_state_r <= '0;
    end else begin
      wp_r       <= wp_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      lp_state_r <= lp_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) begin
      s1_r <= mem[rd1_r];
      s2_r <= mem[rd2_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd1_r  <= rd1;
      rd2_r  <= rd2;
      x_r    <= sample_in;
      frac_r <= cfg.delay_fraction;
      g1e_r  <= g1e;
      g2e_r  <= g2e;
    end
    if (cmd.mul) begin
      pi_r <= diff * $signed({1'b0, frac_r});
      pl_r <= $signed({1'b0, g2e_r}) * lp_state_r;
    end
    if (cmd.dly) dly_r <= dly_sum[SB-1:0];
    if (cmd.fb)  pf_r  <= $signed({1'b0, g1e_r}) * lp_state_r;
    if (cmd.wr)  out_r <= dly_r;
  end

endmodule

[tb/sv/tb.sv]
// testbench for lowpass_feedback_comb_filter: drives sample and clear words
// with random gaps and output stalls, predicts every delayed sample and checks
// it; depends on lfcf_pkg and the filter rtl
module tb;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam logic [lfcf_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST =
    lfcf_pkg::REG_LOWPASS_GAIN + 1'b1;

  typedef logic signed [lfcf_pkg::SAMPLE_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = lfcf_pkg::OP_PROCESS;
  sample_t in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfcf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lowpass_feedback_comb_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter state and registers as the block should hold them
  sample_t ring_mem [lfcf_pkg::DEPTH];
  logic [lfcf_pkg::ADDR_W-1:0] ring_wp;
  longint lp_acc;
  logic [lfcf_pkg::WHOLE_W-1:0] m_whole;
  logic [lfcf_pkg::FRAC_BITS-1:0] m_frac;
  logic [lfcf_pkg::GAIN_W-1:0] m_fb_gain;
  logic [lfcf_pkg::GAIN_W-1:0] m_lp_gain;

  sample_t delayed_q[$];
  sample_t check_want;
  int errors = 0;
  int words_sent = 0;
  int clears_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int free_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void ring_clear();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_wp = '0;
    lp_acc = 0;
  endfunction

  function automatic void apply_reg(logic [lfcf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lfcf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lfcf_pkg::REG_DELAY_WHOLE: m_whole = data[lfcf_pkg::WHOLE_W-1:0];
      lfcf_pkg::REG_DELAY_FRACTION: m_frac = data[lfcf_pkg::FRAC_BITS-1:0];
      lfcf_pkg::REG_FEEDBACK_GAIN: m_fb_gain = data[lfcf_pkg::GAIN_W-1:0];
      lfcf_pkg::REG_LOWPASS_GAIN: m_lp_gain = data[lfcf_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample through the comb: returns the interpolated delayed sample
  function automatic sample_t comb_step(sample_t x);
    longint whole, s_near, s_far, dly, g1e, g2e, lp, wr;
    logic [lfcf_pkg::ADDR_W-1:0] tap_near, tap_far;
    whole = m_whole;
    if (whole < 1) whole = 1;
    if (whole > lfcf_pkg::DEPTH - 1) whole = lfcf_pkg::DEPTH - 1;
    tap_near = ring_wp - lfcf_pkg::ADDR_W'(whole);
    tap_far = tap_near - 1'b1;
    // far tap may be the slot written below, so read it first
    s_near = ring_mem[tap_near];
    s_far = ring_mem[tap_far];
    dly = s_near + round_half_up((s_far - s_near) * longint'(m_frac),
                                 lfcf_pkg::FRAC_BITS);
    g2e = (m_lp_gain > lfcf_pkg::GAIN_LIMIT) ? lfcf_pkg::GAIN_LIMIT : m_lp_gain;
    g1e = m_fb_gain;
    if (g1e > longint'(lfcf_pkg::GAIN_LIMIT) - g2e)
      g1e = longint'(lfcf_pkg::GAIN_LIMIT) - g2e;
    lp = clip(dly + round_half_up(g2e * lp_acc, lfcf_pkg::GAIN_W), lfcf_pkg::LP_W);
    lp_acc = lp;
    wr = clip(longint'(x) + round_half_up(g1e * lp, lfcf_pkg::GAIN_W),
              lfcf_pkg::SAMPLE_BITS);
    ring_mem[ring_wp] = sample_t'(wr);
    ring_wp = (ring_wp == lfcf_pkg::ADDR_W'(lfcf_pkg::DEPTH - 1)) ? '0 : ring_wp + 1'b1;
    return sample_t'(dly);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 7)) - 16'sd4;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [lfcf_pkg::CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      2: return lfcf_pkg::GAIN_LIMIT;
      3: return lfcf_pkg::GAIN_LIMIT + 1'b1;
      4: return lfcf_pkg::CFG_DATA_W'($urandom_range(60000, 65535));
      default: return lfcf_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  // receiver stalls, with stretches of no stalls at all
  always @(negedge clk) begin
    if (rx_calm) begin
      out_stall <= 1'b0;
      hold_left = 0;
      free_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      hold_left = pick_gap();
      free_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 100) : $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (delayed_q.size() == 0) begin
        errors++;
        $display("%0t: sample_out expected none got %0d", $time, out_sample_out);
      end else begin
        check_want = delayed_q.pop_front();
        if (out_sample_out !== check_want) begin
          errors++;
          $display("%0t: sample_out expected %0d got %0d", $time, check_want,
                   out_sample_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, delayed_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_word(input logic op, input sample_t smp);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == lfcf_pkg::OP_CLEAR) begin
      ring_clear();
      clears_sent++;
    end else begin
      delayed_q.push_back(comb_step(smp));
      words_sent++;
    end
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [lfcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfcf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block idle: every word back, pipeline flushed, clearing pass done
  task automatic settle();
    drop_input();
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    settle();
    // an index past the last register must leave delay_whole alone
    write_reg(REG_UNUSED_FIRST, 16'd1);
    send_word(lfcf_pkg::OP_PROCESS, 16'sh7FFF);
    send_word(lfcf_pkg::OP_PROCESS, 16'sh8000);
    send_word(lfcf_pkg::OP_PROCESS, '0);
    send_word(lfcf_pkg::OP_PROCESS, 16'sh0001);
  endtask

  task automatic test_extremes();
    settle();
    // zero delay acts as one, lowpass gain clamps and squeezes g1 to zero
    write_reg(lfcf_pkg::REG_DELAY_WHOLE, '0);
    write_reg(lfcf_pkg::REG_DELAY_FRACTION, 16'hFFFF);
    write_reg(lfcf_pkg::REG_FEEDBACK_GAIN, 16'hFFFF);
    write_reg(lfcf_pkg::REG_LOWPASS_GAIN, 16'hFFFF);
    repeat (3) send_word(lfcf_pkg::OP_PROCESS, 16'sh7FFF);
    repeat (2) send_word(lfcf_pkg::OP_PROCESS, 16'sh8000);
    settle();
    // full feedback drives the written value into saturation
    write_reg(lfcf_pkg::REG_DELAY_WHOLE, 16'd1);
    write_reg(lfcf_pkg::REG_DELAY_FRACTION, '0);
    write_reg(lfcf_pkg::REG_LOWPASS_GAIN, '0);
    repeat (3) send_word(lfcf_pkg::OP_PROCESS, 16'sh7FFF);
    repeat (3) send_word(lfcf_pkg::OP_PROCESS, 16'sh8000);
    send_word(lfcf_pkg::OP_CLEAR, 16'sh7FFF);
    send_word(lfcf_pkg::OP_PROCESS, 16'sh8000);
    send_word(lfcf_pkg::OP_PROCESS, 16'sh7FFF);
  endtask

  // longest delay: both taps wrap behind the pointer, far tap is the slot
  // being overwritten
  task automatic test_ring_wrap();
    settle();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_reg(lfcf_pkg::REG_DELAY_WHOLE, 16'hFFFF);
    write_reg(lfcf_pkg::REG_DELAY_FRACTION, 16'd200);
    write_reg(lfcf_pkg::REG_FEEDBACK_GAIN, 16'd30000);
    write_reg(lfcf_pkg::REG_LOWPASS_GAIN, 16'd20000);
    repeat (30) send_word(lfcf_pkg::OP_PROCESS, sample_t'($urandom));
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // steady full-scale input pushes the lowpass state into its 24-bit limit
  task automatic test_lowpass_saturation();
    settle();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_reg(lfcf_pkg::REG_DELAY_WHOLE, 16'd1);
    write_reg(lfcf_pkg::REG_DELAY_FRACTION, '0);
    write_reg(lfcf_pkg::REG_FEEDBACK_GAIN, '0);
    write_reg(lfcf_pkg::REG_LOWPASS_GAIN, 16'hFFFF);
    repeat (320) send_word(lfcf_pkg::OP_PROCESS, 16'sh7FFF);
    repeat (20) send_word(lfcf_pkg::OP_PROCESS, pick_sample());
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [lfcf_pkg::CFG_DATA_W-1:0] whole_data;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case ($urandom_range(0, 5))
        0: whole_data = '0;
        1: whole_data = 16'hFFFF;
        2: whole_data = lfcf_pkg::CFG_DATA_W'($urandom);
        default: whole_data = lfcf_pkg::CFG_DATA_W'($urandom_range(1, 24));
      endcase
      write_reg(lfcf_pkg::REG_DELAY_WHOLE, whole_data);
      case ($urandom_range(0, 3))
        0: write_reg(lfcf_pkg::REG_DELAY_FRACTION, '0);
        1: write_reg(lfcf_pkg::REG_DELAY_FRACTION, 16'd255);
        default: write_reg(lfcf_pkg::REG_DELAY_FRACTION, lfcf_pkg::CFG_DATA_W'($urandom));
      endcase
      write_reg(lfcf_pkg::REG_FEEDBACK_GAIN, pick_gain());
      write_reg(lfcf_pkg::REG_LOWPASS_GAIN, pick_gain());
      if ($urandom_range(0, 2) == 0)
        write_reg(lfcf_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST,
                                                      (1 << lfcf_pkg::CFG_IDX_W) - 1)),
                  lfcf_pkg::CFG_DATA_W'($urandom));
      tx_calm = (phase == 5);
      rx_calm = (phase == 5);
      for (int n = 0; n < 30; n++) begin
        // sender holds off until the pipeline has drained
        if (phase == 2 && n == 15) begin
          drop_input();
          while (delayed_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0)
          send_word(lfcf_pkg::OP_CLEAR, pick_sample());
        else
          send_word(lfcf_pkg::OP_PROCESS, pick_sample());
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    m_whole = lfcf_pkg::WHOLE_W'(1323);
    m_frac = '0;
    m_fb_gain = lfcf_pkg::GAIN_W'(6554);
    m_lp_gain = '0;
    ring_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extremes();
    test_ring_wrap();
    test_lowpass_saturation();
    test_random_phases();

    settle();
    repeat (16) @(posedge clk);
    $display("sent %0d sample words and %0d clears, %0d register writes",
             words_sent, clears_sent, reg_writes);
    $display("checked %0d delayed samples, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
